>>> src/wsqs_pkg.sv
// Package with the shared types, constants and helper functions of the severity queue scheduler.
package wsqs_pkg;

    // Sizing of the queue store and the weighted schedule.
    localparam int MAX_ENTRIES    = 64;
    localparam int HANDLE_BITS    = 16;
    localparam int SCHEDULE_SLOTS = 11;
    localparam int LEVELS         = 5;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int PTR_W  = $clog2(SCHEDULE_SLOTS);
    localparam int ADDR_W = $clog2(LEVELS * MAX_ENTRIES);
    localparam int DEPTH  = LEVELS * MAX_ENTRIES;

    // Fixed field widths of the transactions and the register.
    localparam int LVL_W  = 3;
    localparam int HND_W  = HANDLE_BITS;
    localparam int CAP_W  = 7;
    localparam int OCC_W  = 7;
    localparam int DATA_W = 32;
    localparam int PADDR_W = 3;

    // Levels with a fixed meaning.
    localparam logic [LVL_W-1:0] LEVEL_CRITICAL = 3'd0;
    localparam logic [LVL_W-1:0] LEVEL_DEBUG    = 3'd4;

    // Register map: register index taken from the word address.
    localparam logic REG_TOTAL_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

    // Request action codes.
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ENQUEUED = 2'd0,
        STATUS_DEQUEUED = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic             action;
        logic [LVL_W-1:0] severity;
        logic [HND_W-1:0] entry_handle;
        logic             end_marker;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [HND_W-1:0] out_handle;
        logic             out_end_marker;
        logic [LVL_W-1:0] served_level;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    // One stored entry: handle plus stop sentinel bit.
    typedef struct packed {
        logic [HND_W-1:0] handle;
        logic             marker;
    } entry_t;

    // Level served by one slot of the weighted schedule (4,3,2,1,1 slots).
    function automatic logic [LVL_W-1:0] slot_level(input logic [PTR_W-1:0] s);
        logic [LVL_W-1:0] lvl;
        begin
            if (s < PTR_W'(4)) lvl = 3'd0;
            else if (s < PTR_W'(7)) lvl = 3'd1;
            else if (s < PTR_W'(9)) lvl = 3'd2;
            else if (s < PTR_W'(10)) lvl = 3'd3;
            else lvl = 3'd4;
            return lvl;
        end
    endfunction

endpackage

>>> src/weighted_severity_queue_scheduler.sv
// Top level of the weighted severity queue scheduler with its queue store and schedule logic.
// An enqueue or a rejected or empty transaction registers its result on acceptance; a
// successful dequeue reads its entry into the registered read port and then registers its
// result. One enqueue per cycle while results are taken; a dequeue blocks requests during
// its memory read. Reset clears all queue pointers, fill counts and the schedule pointer
// and sets the capacity to 64; the queue memory is not cleared and needs no clearing pass.
module weighted_severity_queue_scheduler
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  wsqs_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output wsqs_pkg::rsp_t                 rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wsqs_pkg::PADDR_W-1:0]   paddr,
    input  logic [wsqs_pkg::DATA_W-1:0]    pwdata,
    output logic [wsqs_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t                               state_reg;
    logic [wsqs_pkg::CAP_W-1:0]           capacity_reg;
    logic [wsqs_pkg::IDX_W-1:0]           head_reg [wsqs_pkg::LEVELS];
    logic [wsqs_pkg::IDX_W-1:0]           tail_reg [wsqs_pkg::LEVELS];
    logic [wsqs_pkg::FILL_W-1:0]          level_fill_reg [wsqs_pkg::LEVELS];
    logic [wsqs_pkg::FILL_W-1:0]          total_fill_reg;
    logic [wsqs_pkg::PTR_W-1:0]           sched_ptr_reg;
    logic [wsqs_pkg::LVL_W-1:0]           pend_level_reg;
    logic                                 rsp_valid_reg;
    wsqs_pkg::rsp_t                       rsp_reg;

    // Queue memory and its registered read port.
    wsqs_pkg::entry_t                     mem [wsqs_pkg::DEPTH];
    wsqs_pkg::entry_t                     rd_data_reg;

    logic                                 req_fire;
    logic                                 rsp_load;
    logic                                 cfg_write;
    logic [wsqs_pkg::CAP_W-1:0]           cap_eff;
    logic                                 is_full;
    logic [wsqs_pkg::LVL_W-1:0]           enq_level;
    wsqs_pkg::entry_t                     enq_entry;
    logic [wsqs_pkg::LEVELS-1:0]          nonempty;
    logic [wsqs_pkg::SCHEDULE_SLOTS-1:0]  slot_hit;
    logic                                 pick_found;
    logic [wsqs_pkg::PTR_W-1:0]           pick_slot;
    logic [wsqs_pkg::PTR_W-1:0]           pick_ptr_next;
    logic [wsqs_pkg::LVL_W-1:0]           pick_level;
    logic                                 mem_wr_en;
    logic                                 mem_rd_en;
    logic [wsqs_pkg::ADDR_W-1:0]          wr_addr;
    logic [wsqs_pkg::ADDR_W-1:0]          rd_addr;

    // Handshake and configuration port.
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[wsqs_pkg::PADDR_W-1] == wsqs_pkg::REG_TOTAL_CAPACITY)
        begin
            prdata = {{(wsqs_pkg::DATA_W - wsqs_pkg::CAP_W){1'b0}}, capacity_reg};
        end
    end

    // Effective capacity and full check.
    assign cap_eff = (capacity_reg > wsqs_pkg::CAP_W'(wsqs_pkg::MAX_ENTRIES)) ?
                     wsqs_pkg::CAP_W'(wsqs_pkg::MAX_ENTRIES) : capacity_reg;
    assign is_full = wsqs_pkg::CAP_W'(total_fill_reg) >= cap_eff;

    // Level and entry for an enqueue; a stop sentinel goes to the critical level.
    always_comb
    begin
        if (req.end_marker)
        begin
            enq_level        = wsqs_pkg::LEVEL_CRITICAL;
            enq_entry.handle = '0;
            enq_entry.marker = 1'b1;
        end
        else
        begin
            enq_level        = (req.severity > wsqs_pkg::LEVEL_DEBUG) ?
                               wsqs_pkg::LEVEL_DEBUG : req.severity;
            enq_entry.handle = req.entry_handle;
            enq_entry.marker = 1'b0;
        end
    end

    // Rotated priority pick over the weighted schedule slots.
    always_comb
    begin
        logic [wsqs_pkg::PTR_W:0] sum;
        logic [wsqs_pkg::PTR_W-1:0] idx;
        for (int l = 0; l < wsqs_pkg::LEVELS; l++)
        begin
            nonempty[l] = (level_fill_reg[l] != '0);
        end
        for (int s = 0; s < wsqs_pkg::SCHEDULE_SLOTS; s++)
        begin
            slot_hit[s] = nonempty[wsqs_pkg::slot_level(wsqs_pkg::PTR_W'(s))];
        end
        pick_found = 1'b0;
        pick_slot  = '0;
        for (int a = 0; a < wsqs_pkg::SCHEDULE_SLOTS; a++)
        begin
            sum = {1'b0, sched_ptr_reg} + (wsqs_pkg::PTR_W + 1)'(a);
            if (sum >= (wsqs_pkg::PTR_W + 1)'(wsqs_pkg::SCHEDULE_SLOTS))
            begin
                sum = sum - (wsqs_pkg::PTR_W + 1)'(wsqs_pkg::SCHEDULE_SLOTS);
            end
            idx = sum[wsqs_pkg::PTR_W-1:0];
            if (!pick_found && slot_hit[idx])
            begin
                pick_found = 1'b1;
                pick_slot  = idx;
            end
        end
        pick_level    = wsqs_pkg::slot_level(pick_slot);
        pick_ptr_next = (pick_slot == wsqs_pkg::PTR_W'(wsqs_pkg::SCHEDULE_SLOTS - 1)) ?
                        '0 : pick_slot + 1'b1;
    end

    // Memory access controls.
    assign mem_wr_en = req_fire && (req.action == wsqs_pkg::ACT_ENQUEUE) && !is_full;
    assign mem_rd_en = req_fire && (req.action == wsqs_pkg::ACT_DEQUEUE) && pick_found;
    assign wr_addr   = wsqs_pkg::ADDR_W'(enq_level) * wsqs_pkg::ADDR_W'(wsqs_pkg::MAX_ENTRIES)
                       + wsqs_pkg::ADDR_W'(tail_reg[enq_level]);
    assign rd_addr   = wsqs_pkg::ADDR_W'(pick_level) * wsqs_pkg::ADDR_W'(wsqs_pkg::MAX_ENTRIES)
                       + wsqs_pkg::ADDR_W'(head_reg[pick_level]);

    // A result is ready this cycle unless the transaction still waits for the memory read.
    assign rsp_load  = (state_reg == S_READ) || (req_fire && !mem_rd_en);

    // Queue memory with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[wr_addr] <= enq_entry;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state, queue pointers and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            capacity_reg   <= wsqs_pkg::CAPACITY_RESET;
            total_fill_reg <= '0;
            sched_ptr_reg  <= '0;
            pend_level_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
            for (int l = 0; l < wsqs_pkg::LEVELS; l++)
            begin
                head_reg[l]       <= '0;
                tail_reg[l]       <= '0;
                level_fill_reg[l] <= '0;
            end
        end
        else
        begin
            if (cfg_write && (paddr[wsqs_pkg::PADDR_W-1] == wsqs_pkg::REG_TOTAL_CAPACITY))
            begin
                capacity_reg <= pwdata[wsqs_pkg::CAP_W-1:0];
            end
            // The result register fills on a finished transaction and empties when taken.
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        rsp_reg.out_handle     <= '0;
                        rsp_reg.out_end_marker <= 1'b0;
                        rsp_reg.served_level   <= '0;
                        if (req.action == wsqs_pkg::ACT_ENQUEUE)
                        begin
                            if (is_full)
                            begin
                                rsp_reg.status    <= wsqs_pkg::STATUS_FULL;
                                rsp_reg.occupancy <= wsqs_pkg::OCC_W'(total_fill_reg);
                            end
                            else
                            begin
                                rsp_reg.status      <= wsqs_pkg::STATUS_ENQUEUED;
                                rsp_reg.occupancy   <= wsqs_pkg::OCC_W'(total_fill_reg + 1'b1);
                                tail_reg[enq_level] <= (tail_reg[enq_level] ==
                                    wsqs_pkg::IDX_W'(wsqs_pkg::MAX_ENTRIES - 1)) ?
                                    '0 : tail_reg[enq_level] + 1'b1;
                                level_fill_reg[enq_level] <= level_fill_reg[enq_level] + 1'b1;
                                total_fill_reg <= total_fill_reg + 1'b1;
                            end
                        end
                        else if (!pick_found)
                        begin
                            rsp_reg.status    <= wsqs_pkg::STATUS_EMPTY;
                            rsp_reg.occupancy <= wsqs_pkg::OCC_W'(total_fill_reg);
                        end
                        else
                        begin
                            // Pointers move now; the entry arrives from memory next cycle.
                            head_reg[pick_level] <= (head_reg[pick_level] ==
                                wsqs_pkg::IDX_W'(wsqs_pkg::MAX_ENTRIES - 1)) ?
                                '0 : head_reg[pick_level] + 1'b1;
                            level_fill_reg[pick_level] <= level_fill_reg[pick_level] - 1'b1;
                            total_fill_reg <= total_fill_reg - 1'b1;
                            sched_ptr_reg  <= pick_ptr_next;
                            pend_level_reg <= pick_level;
                            state_reg      <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    rsp_reg.status         <= wsqs_pkg::STATUS_DEQUEUED;
                    rsp_reg.out_handle     <= rd_data_reg.handle;
                    rsp_reg.out_end_marker <= rd_data_reg.marker;
                    rsp_reg.served_level   <= pend_level_reg;
                    rsp_reg.occupancy      <= wsqs_pkg::OCC_W'(total_fill_reg);
                    state_reg              <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The result register is free while a memory read is outstanding.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !rsp_valid_reg)
        else $error("result pending during memory read");

    // The total fill always equals the sum of the level fills.
    assert property (@(posedge clk) disable iff (!rst_n)
        total_fill_reg == (level_fill_reg[0] + level_fill_reg[1] + level_fill_reg[2]
                           + level_fill_reg[3] + level_fill_reg[4]))
        else $error("total fill out of step with level fills");

    // The store never holds more entries than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n)
        total_fill_reg <= wsqs_pkg::FILL_W'(wsqs_pkg::MAX_ENTRIES))
        else $error("total fill beyond store size");

    // A dequeue that finds an entry always waits for the memory read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.action == wsqs_pkg::ACT_DEQUEUE) && pick_found)
        |=> (state_reg == S_READ))
        else $error("dequeue did not start a memory read");

    // An accepted enqueue never pushes the fill beyond the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (wsqs_pkg::CAP_W'(total_fill_reg) < cap_eff))
        else $error("enqueue written while full");
`endif

endmodule
